/* sv/sca_pkg.sv */
// Shared types and constants of the set coprimality classifier.
`default_nettype none

package sca_pkg;

    // Verdict codes on the result channel
    localparam logic [1:0] VERDICT_PAIRWISE = 2'd0;
    localparam logic [1:0] VERDICT_SETWISE  = 2'd1;
    localparam logic [1:0] VERDICT_NONE     = 2'd2;

    // Seen-prime store organization: 32 flags per word plus a set tag
    localparam int WORD_BITS     = 32;
    localparam int WORD_SEL_BITS = 5;
    localparam int EPOCH_BITS    = 8;

    localparam logic [EPOCH_BITS-1:0] EPOCH_CLEAR = '0;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

    typedef logic [1:0] t_verdict;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] tag;
        logic [WORD_BITS-1:0]  flags;
    } t_seen_word;

    // Status of the seen-prime store toward the sequencer
    typedef struct packed {
        logic busy;   // clearing pass in progress
        logic done;   // read-modify-write finished this cycle
        logic hit;    // prime was already present (valid with done)
    } t_seen_stat;

    // Status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

/* sv/sca_in_if.sv */
// Request channel carrying one set element and its end-of-set flag.
`default_nettype none

interface sca_in_if #(
    parameter int VALUE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

/* sv/sca_out_if.sv */
// Result channel carrying one verdict per set.
`default_nettype none

interface sca_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

/* sv/sca_div.sv */
// Restoring divider, one quotient bit per cycle, shared by gcd and trial division.
`default_nettype none

module sca_div #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [VALUE_BITS-1:0] i_dividend,
    input  wire logic [VALUE_BITS-1:0] i_divisor,
    output sca_pkg::t_div_stat         o_stat,
    output logic      [VALUE_BITS-1:0] o_quo,
    output logic      [VALUE_BITS-1:0] o_rem
);
    import sca_pkg::*;

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [VALUE_BITS-1:0] r_div;
    logic [VALUE_BITS-1:0] r_quo;
    logic [VALUE_BITS-1:0] r_rem;

    logic [VALUE_BITS:0]   trial;
    logic                  take;
    logic [VALUE_BITS:0]   diff;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial = {r_rem, r_quo[VALUE_BITS-1]};
        take  = (trial >= {1'b0, r_div});
        diff  = trial - {1'b0, r_div};
    end

    // Control: count quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(VALUE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_BITS-2:0], take};
            r_rem <= take ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
    assign o_rem       = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

endmodule

`default_nettype wire

/* sv/sca_seen.sv */
// Seen-prime store: tagged flag words in one memory, read-modify-write per prime.
`default_nettype none

module sca_seen #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_note,
    input  wire logic [VALUE_BITS-1:0] i_prime,
    input  wire logic                  i_advance,
    output sca_pkg::t_seen_stat        o_stat
);
    import sca_pkg::*;

    localparam int WORDS     = (2 ** VALUE_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_BITS = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_RMW   = 2'd2;

    t_seen_word r_mem [WORDS];

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [EPOCH_BITS-1:0]  r_epoch;
    logic [ADDR_BITS-1:0]   r_clr_addr;
    logic [ADDR_BITS-1:0]   r_addr;
    logic [WORD_SEL_BITS-1:0] r_bit;
    t_seen_word             r_rd_data;

    logic [VALUE_BITS-1:0]               word_full;
    logic [VALUE_BITS+WORD_SEL_BITS-1:0] prime_ext;
    logic [ADDR_BITS-1:0]                rd_addr;
    logic [WORD_BITS-1:0]                old_flags;
    logic                                mem_we;
    logic [ADDR_BITS-1:0]                wr_addr;
    t_seen_word                          wr_data;

    // Split the prime into word address and flag position
    always_comb begin
        word_full = i_prime >> WORD_SEL_BITS;
        prime_ext = {{WORD_SEL_BITS{1'b0}}, i_prime};
        rd_addr   = word_full[ADDR_BITS-1:0];
    end

    // Merge the new flag into the word; a stale tag reads as empty
    always_comb begin
        old_flags = (r_rd_data.tag == r_epoch) ? r_rd_data.flags : '0;
        mem_we    = 1'b0;
        wr_addr   = r_addr;
        wr_data   = '{tag: r_epoch, flags: old_flags | (WORD_BITS'(1) << r_bit)};
        case (r_state)
            S_CLEAR: begin
                mem_we  = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '{tag: EPOCH_CLEAR, flags: '0};
            end
            S_RMW: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == ADDR_BITS'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_note) begin
                    n_state = S_RMW;
                end else if (i_advance && r_epoch == EPOCH_LAST) begin
                    n_state = S_CLEAR;
                end
            end
            S_RMW: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control: state, clearing sweep and set tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_epoch    <= EPOCH_FIRST;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_BITS'(1);
            end else begin
                r_clr_addr <= '0;
            end
            if (r_state == S_IDLE && i_advance) begin
                r_epoch <= (r_epoch == EPOCH_LAST) ? EPOCH_FIRST : r_epoch + EPOCH_BITS'(1);
            end
        end
    end

    // Hold the location of the pending update
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_note) begin
            r_addr <= rd_addr;
            r_bit  <= prime_ext[WORD_SEL_BITS-1:0];
        end
    end

    assign o_stat.busy = (r_state == S_CLEAR);
    assign o_stat.done = (r_state == S_RMW);
    assign o_stat.hit  = old_flags[r_bit];

    a_note_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_note |-> r_state == S_IDLE)
        else $error("prime noted while store busy");

    a_advance_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance |-> (r_state == S_IDLE && !i_note))
        else $error("set advanced while store busy");

endmodule

`default_nettype wire

/* sv/set_coprimality_classifier.sv */
// Top level: sequencer for gcd, trial division and the verdict of each set.
//
//   channel  dir  payload              handshake
//   i_in     in   value, last          valid/ready
//   o_out    out  verdict (2 bits)     valid/ready
//
// One element at a time; each divide goes through the shared divider. An element
// runs its gcd steps, then trial divides by 2, 3 and the odd candidates up to
// sqrt(n), once more for every repeated factor, with a check state per gcd step
// and candidate and a store update per distinct prime factor. After reset and
// after every 255th set, a clearing pass over ceil(2^VALUE_BITS / 32) words runs
// and takes no request. A held verdict blocks only the end of the next set.
`default_nettype none

module set_coprimality_classifier #(
    parameter int VALUE_BITS = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    sca_in_if.sink   i_in,
    sca_out_if.source o_out
);
    import sca_pkg::*;

    localparam int DSQ_BITS = VALUE_BITS + 2;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GCHK  = 4'd1;
    localparam logic [3:0] S_GDIV  = 4'd2;
    localparam logic [3:0] S_GWAIT = 4'd3;
    localparam logic [3:0] S_TCHK  = 4'd4;
    localparam logic [3:0] S_TDIV  = 4'd5;
    localparam logic [3:0] S_TWAIT = 4'd6;
    localparam logic [3:0] S_TNOTE = 4'd7;
    localparam logic [3:0] S_LNOTE = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0]            r_state;
    logic [3:0]            n_state;
    logic                  r_last;
    logic [VALUE_BITS-1:0] r_a;
    logic [VALUE_BITS-1:0] r_b;
    logic [VALUE_BITS-1:0] r_gcd;
    logic                  r_shared;
    logic [VALUE_BITS-1:0] r_n;
    logic [VALUE_BITS-1:0] r_d;
    logic [DSQ_BITS-1:0]   r_dsq;
    logic                  r_noted;
    logic                  r_out_valid;
    t_verdict              r_out_verdict;

    t_div_stat             div_stat;
    logic [VALUE_BITS-1:0] div_quo;
    logic [VALUE_BITS-1:0] div_rem;
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic [VALUE_BITS-1:0] div_divisor;

    t_seen_stat            seen_stat;
    logic                  note;
    logic [VALUE_BITS-1:0] note_prime;
    logic                  advance;

    logic                  accept;
    logic                  out_free;
    logic                  past_root;
    t_verdict              verdict;

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign past_root = r_dsq > {2'b00, r_n};

    // Pick the verdict from the shared flag and the gcd
    always_comb begin
        if (!r_shared) begin
            verdict = VERDICT_PAIRWISE;
        end else if (r_gcd == VALUE_BITS'(1)) begin
            verdict = VERDICT_SETWISE;
        end else begin
            verdict = VERDICT_NONE;
        end
    end

    // Drive the divider and the seen-prime store
    always_comb begin
        div_start    = (r_state == S_GDIV) || (r_state == S_TDIV);
        div_dividend = (r_state == S_GDIV) ? r_a : r_n;
        div_divisor  = (r_state == S_GDIV) ? r_b : r_d;
        note_prime   = (r_state == S_TCHK) ? r_n : r_d;
        note         = 1'b0;
        case (r_state)
            S_TCHK:  note = past_root && (r_n > VALUE_BITS'(1));
            S_TWAIT: note = div_stat.done && (div_rem == '0) && !r_noted;
            default: note = 1'b0;
        endcase
        advance = (r_state == S_FIN) && r_last && out_free;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in.value == '0) ? S_FIN : S_GCHK;
                end
            end
            S_GCHK:  n_state = (r_b == '0) ? S_TCHK : S_GDIV;
            S_GDIV:  n_state = S_GWAIT;
            S_GWAIT: begin
                if (div_stat.done) begin
                    n_state = S_GCHK;
                end
            end
            S_TCHK: begin
                if (past_root) begin
                    n_state = (r_n > VALUE_BITS'(1)) ? S_LNOTE : S_FIN;
                end else begin
                    n_state = S_TDIV;
                end
            end
            S_TDIV:  n_state = S_TWAIT;
            S_TWAIT: begin
                if (div_stat.done) begin
                    if (div_rem != '0) begin
                        n_state = S_TCHK;
                    end else if (!r_noted) begin
                        n_state = S_TNOTE;
                    end else begin
                        n_state = S_TDIV;
                    end
                end
            end
            S_TNOTE: begin
                if (seen_stat.done) begin
                    n_state = S_TDIV;
                end
            end
            S_LNOTE: begin
                if (seen_stat.done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_last || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and per-set state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gcd    <= '0;
            r_shared <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (accept && i_in.value == '0) begin
                        r_shared <= 1'b1;
                    end
                end
                S_GCHK: begin
                    if (r_b == '0) begin
                        r_gcd <= r_a;
                    end
                end
                S_TNOTE, S_LNOTE: begin
                    if (seen_stat.done && seen_stat.hit) begin
                        r_shared <= 1'b1;
                    end
                end
                S_FIN: begin
                    if (r_last && out_free) begin
                        r_gcd    <= '0;
                        r_shared <= 1'b0;
                    end
                end
                default: begin
                    r_shared <= r_shared;
                end
            endcase
        end
    end

    // Element datapath: gcd operands, trial divisor and remaining cofactor
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_last <= i_in.last;
                    r_a    <= r_gcd;
                    r_b    <= i_in.value;
                    r_n    <= i_in.value;
                end
            end
            S_GCHK: begin
                r_d     <= VALUE_BITS'(2);
                r_dsq   <= DSQ_BITS'(4);
                r_noted <= 1'b0;
            end
            S_GWAIT: begin
                if (div_stat.done) begin
                    r_a <= r_b;
                    r_b <= div_rem;
                end
            end
            S_TWAIT: begin
                if (div_stat.done) begin
                    if (div_rem == '0) begin
                        r_n     <= div_quo;
                        r_noted <= 1'b1;
                    end else begin
                        // Step to the next candidate: 2, 3, then odd only
                        r_noted <= 1'b0;
                        if (r_d == VALUE_BITS'(2)) begin
                            r_d   <= VALUE_BITS'(3);
                            r_dsq <= DSQ_BITS'(9);
                        end else begin
                            r_d   <= r_d + VALUE_BITS'(2);
                            r_dsq <= r_dsq + ({2'b00, r_d} << 2) + DSQ_BITS'(4);
                        end
                    end
                end
            end
            default: begin
                r_a <= r_a;
            end
        endcase
    end

    // Result register: load at end of set, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_verdict <= verdict;
        end
    end

    assign i_in.ready    = (r_state == S_IDLE) && !seen_stat.busy;
    assign o_out.valid   = r_out_valid;
    assign o_out.verdict = r_out_verdict;

    sca_div #(
        .VALUE_BITS(VALUE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    sca_seen #(
        .VALUE_BITS(VALUE_BITS)
    ) u_seen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_note    (note),
        .i_prime   (note_prime),
        .i_advance (advance),
        .o_stat    (seen_stat)
    );

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_GWAIT || r_state == S_TWAIT))
        else $error("divider result arrived with no one waiting");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> div_divisor != '0)
        else $error("divide by zero issued");

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the set coprimality classifier: directed sets, then random sets.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sca_pkg::*;

    localparam int VALUE_BITS   = 16;
    localparam int N_DIRECTED   = 26;
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_AT      = 30;     // verdict count at which the sink holds off
    localparam int HOLD_CYCLES  = 30000;
    localparam int DRAIN_CYCLES = 4000;
    localparam int PRINT_LIMIT  = 50;

    typedef logic [VALUE_BITS-1:0] t_value;

    // Kind of set the random part builds
    typedef enum int unsigned {
        SHAPE_MIXED,     // any values, small ones mostly
        SHAPE_COMMON,    // every element carries one common factor
        SHAPE_DISJOINT,  // powers of distinct primes
        SHAPE_TANGLED    // products of two primes out of a pool of four
    } t_set_shape;

    // One directed request; verdict is used only where fixed is set
    typedef struct packed {
        t_value   value;
        logic     last;
        logic     fixed;
        t_verdict verdict;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sca_in_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
    sca_out_if                           verdict_ch ();

    set_coprimality_classifier #(
        .VALUE_BITS(VALUE_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (req_ch),
        .o_out  (verdict_ch)
    );

    // Set state of the predictor
    bit          seen_prime [int unsigned];
    t_value      set_gcd        = '0;
    bit          prime_repeated = 1'b0;
    t_verdict    verdict_q [$];

    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned tx_calm        = 0;
    int unsigned rx_calm        = 0;

    int unsigned small_primes [15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
    t_value      corner_values [8] = '{16'd1, 16'd65535, 16'd65521, 16'd65519,
                                       16'd32768, 16'd65534, 16'd64507, 16'd65025};

    t_stim_row directed_rows [N_DIRECTED] = '{
        // single-element sets are pairwise coprime whatever the value
        '{16'd1,     1'b1, 1'b1, VERDICT_PAIRWISE},
        '{16'd65535, 1'b1, 1'b1, VERDICT_PAIRWISE},
        '{16'd65521, 1'b1, 1'b1, VERDICT_PAIRWISE},
        '{16'd2,     1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd4,     1'b1, 1'b0, VERDICT_PAIRWISE},
        '{16'd6,     1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd10,    1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd15,    1'b1, 1'b0, VERDICT_PAIRWISE},
        // ones have no prime factors
        '{16'd1,     1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd1,     1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd1,     1'b1, 1'b0, VERDICT_PAIRWISE},
        '{16'd32768, 1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd65535, 1'b1, 1'b0, VERDICT_PAIRWISE},
        // repeated top value and repeated large prime share everything
        '{16'd65535, 1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd65535, 1'b1, 1'b1, VERDICT_NONE},
        '{16'd65521, 1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd65521, 1'b1, 1'b1, VERDICT_NONE},
        '{16'd2,     1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd3,     1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd5,     1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd7,     1'b1, 1'b0, VERDICT_PAIRWISE},
        '{16'd1,     1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd65534, 1'b1, 1'b0, VERDICT_PAIRWISE},
        // zero shares every prime and leaves the gcd alone
        '{16'd0,     1'b1, 1'b1, VERDICT_NONE},
        '{16'd0,     1'b0, 1'b0, VERDICT_PAIRWISE},
        '{16'd1,     1'b1, 1'b1, VERDICT_SETWISE}
    };

    // Toggle the clock: 4 ns high, 4 ns low
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns mismatch: %0s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned gcd_of(input int unsigned a, input int unsigned b);
        int unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Mark a prime as seen in the current set; flag it when it comes back
    function automatic void note_prime(input int unsigned p);
        if (seen_prime.exists(p))
            prime_repeated = 1'b1;
        seen_prime[p] = 1'b1;
    endfunction

    // Fold one element into the gcd and the seen-prime set
    function automatic void absorb_element(input t_value v);
        int unsigned n;
        int unsigned d;
        n = v;
        if (n == 0) begin
            prime_repeated = 1'b1;
            return;
        end
        set_gcd = t_value'(gcd_of(set_gcd, n));
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) begin
                note_prime(d);
                while (n % d == 0)
                    n = n / d;
            end
        end
        if (n > 1)
            note_prime(n);
    endfunction

    // Classify the finished set and start a fresh one
    function automatic t_verdict close_set();
        t_verdict v;
        if (!prime_repeated)
            v = VERDICT_PAIRWISE;
        else if (set_gcd == 1)
            v = VERDICT_SETWISE;
        else
            v = VERDICT_NONE;
        seen_prime.delete();
        set_gcd        = '0;
        prime_repeated = 1'b0;
        return v;
    endfunction

    // Idle cycles before the next transfer, with bursts of back-to-back transfers
    function automatic int unsigned draw_gap(inout int unsigned calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // Multiply random small primes onto base while staying within limit
    function automatic int unsigned smooth_value(input int unsigned limit,
                                                 input int unsigned base);
        int unsigned v;
        int unsigned p;
        int unsigned n;
        v = base;
        n = $urandom_range(1, 4);
        repeat (n) begin
            p = small_primes[$urandom_range(0, 14)];
            if (v * p <= limit)
                v = v * p;
        end
        return v;
    endfunction

    function automatic t_value pick_value(input t_set_shape shape, input int unsigned factor,
                                          input int unsigned slot);
        int unsigned v;
        int unsigned p;
        int unsigned r;
        int unsigned i;
        int unsigned j;
        v = 1;
        case (shape)
            SHAPE_MIXED: begin
                r = $urandom_range(0, 11);
                if (r <= 5)
                    v = smooth_value(65535, 1);
                else if (r <= 8)
                    v = $urandom_range(1, 300);
                else if (r <= 10)
                    v = $urandom_range(1, 65535);
                else
                    v = corner_values[$urandom_range(0, 7)];
            end
            SHAPE_COMMON: begin
                v = smooth_value(65535, factor);
            end
            SHAPE_DISJOINT: begin
                p = small_primes[slot % 15];
                v = p;
                r = $urandom_range(0, 3);
                repeat (r) begin
                    if (v * p <= 65535)
                        v = v * p;
                end
                if ($urandom_range(0, 7) == 0)
                    v = 1;
            end
            default: begin
                i = $urandom_range(0, 3);
                j = (i + $urandom_range(1, 3)) % 4;
                v = small_primes[i] * small_primes[j];
            end
        endcase
        return t_value'(v);
    endfunction

    // Offer one request and wait for it to be taken; update the predictor on acceptance
    task automatic send_request(input t_value v, input logic l, input logic fixed,
                                input t_verdict fixed_verdict);
        int unsigned gap;
        t_verdict    predicted;
        gap = draw_gap(tx_calm);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.value <= v;
        req_ch.last  <= l;
        do @(posedge i_clk); while (!req_ch.ready);
        absorb_element(v);
        if (l) begin
            predicted = close_set();
            if (fixed)
                predicted = fixed_verdict;
            verdict_q = {verdict_q, predicted};
        end
    endtask

    // Drive reset and all requests, then drain and report
    initial begin : stimulus
        int unsigned k;
        int unsigned set_size;
        int unsigned r;
        int unsigned factor;
        int unsigned start;
        int unsigned random_items;
        t_set_shape  shape;

        req_ch.valid     <= 1'b0;
        req_ch.value     <= '0;
        req_ch.last      <= 1'b0;
        i_rst_n          <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIRECTED; k++)
            send_request(directed_rows[k].value, directed_rows[k].last,
                         directed_rows[k].fixed, directed_rows[k].verdict);

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r <= 1)
                set_size = 1;
            else if (r <= 6)
                set_size = $urandom_range(2, 4);
            else if (r <= 8)
                set_size = $urandom_range(5, 8);
            else
                set_size = $urandom_range(9, 14);
            shape  = t_set_shape'($urandom_range(0, 3));
            factor = smooth_value(400, 1);
            start  = $urandom_range(0, 14);
            for (k = 0; k < set_size; k++)
                send_request(pick_value(shape, factor, start + k), 1'(k == set_size - 1),
                             1'b0, VERDICT_PAIRWISE);
            random_items += set_size;
        end
        req_ch.valid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Take verdicts with random stalls and one long hold-off; check each one
    initial begin : verdict_sink
        int unsigned gap;
        t_verdict    want;
        verdict_ch.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            gap = draw_gap(rx_calm);
            if (results_seen == HOLD_AT)
                gap = HOLD_CYCLES;
            if (gap > 0) begin
                verdict_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            verdict_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!verdict_ch.valid);
            results_seen++;
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("verdict %0d with none pending", verdict_ch.verdict));
            end else begin
                want = verdict_q.pop_front();
                if (verdict_ch.verdict !== want)
                    report_mismatch($sformatf("verdict %0d, expected %0d (set %0d)",
                                              verdict_ch.verdict, want, results_seen));
            end
        end
    end

    // Stop a hung run
    initial begin : watchdog
        #200_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
sv/sca_pkg.sv
sv/sca_in_if.sv
sv/sca_out_if.sv
sv/sca_div.sv
sv/sca_seen.sv
sv/set_coprimality_classifier.sv
test/testbench.sv
